// ===== rtl/alle_pkg.sv =====
package alle_pkg;

    localparam int SLOTS_DEF     = 256;
    localparam int DATA_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SLOT = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

endpackage

// ===== rtl/alle_ram.sv =====
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/array_linked_list_engine_top.sv =====
// Doubly linked list engine over a fixed slot store. Slot 0 is the sentinel;
// unused slots form a free chain through the next links.
// Command channel: a command (i_operation, i_position, i_value) is taken at
// a rising edge with start high and busy low. Each command gives exactly one
// result on o_slot, o_read_value, o_status and o_count, shown for one cycle
// with o_done high. The receiver cannot hold results off; none are dropped
// since busy stays high until the result register is loaded.
// To the result (busy falls as the result appears, so the next command can
// go in the result cycle): insert S_INS_A, S_INS_F, S_INS_W; remove S_REM_A,
// S_REM_W; read S_WALK per link, then S_RD_DATA; range or opcode error from
// S_IDLE; bad slot or full from S_INS_A or S_REM_A. Reads walk one next link
// per cycle through the link memory's read port; insert and remove are bound
// by the one write port of each link memory (two link updates each).
// Reset (synchronous, active low) starts a clearing pass that writes the
// link and used memories one slot per cycle, with busy high throughout.
// The data memory is not cleared; only slots written by an insert are read.
module array_linked_list_engine_top #(
    parameter int SLOTS     = alle_pkg::SLOTS_DEF,
    parameter int DATA_BITS = alle_pkg::DATA_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [7:0]  o_slot,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [7:0]  o_count
);

    import alle_pkg::*;

    localparam int AW = $clog2(SLOTS);

    typedef logic [AW-1:0] t_idx;

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_INS_A   = 9'b000000100,
        S_INS_F   = 9'b000001000,
        S_INS_W   = 9'b000010000,
        S_REM_A   = 9'b000100000,
        S_REM_W   = 9'b001000000,
        S_WALK    = 9'b010000000,
        S_RD_DATA = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_idx   r_init, n_init;
    t_idx   r_head, n_head;
    t_idx   r_tail, n_tail;
    t_idx   r_free, n_free;
    t_idx   r_count, n_count;
    t_idx   r_fresh, n_fresh;
    t_idx   r_nxt, n_nxt;
    t_idx   r_prv, n_prv;
    t_idx   r_cur, n_cur;
    logic [7:0]         r_left, n_left;
    logic [7:0]         r_pos, n_pos;
    logic signed [31:0] r_value, n_value;
    logic               r_done, n_done;
    logic [7:0]         r_slot, n_slot;
    logic [31:0]        r_rdval, n_rdval;
    logic [1:0]         r_status, n_status;
    logic [7:0]         r_cnt, n_cnt;

    // memory ports
    t_idx                 lk_ra;
    t_idx                 dt_ra;
    logic                 nx_we, pv_we, us_we, dt_we;
    t_idx                 nx_wa, pv_wa, us_wa, dt_wa;
    t_idx                 nx_wd, pv_wd;
    logic                 us_wd;
    logic [DATA_BITS-1:0] dt_wd;
    t_idx                 nx_rd, pv_rd;
    logic                 us_rd;
    logic [DATA_BITS-1:0] dt_rd;

    t_idx pidx;
    logic pos_ok;

    assign pidx   = AW'(r_pos);
    assign pos_ok = 32'(r_pos) < 32'(SLOTS);

    alle_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (nx_we),
        .i_waddr(nx_wa),
        .i_wdata(nx_wd),
        .i_raddr(lk_ra),
        .o_rdata(nx_rd)
    );

    alle_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (pv_we),
        .i_waddr(pv_wa),
        .i_wdata(pv_wd),
        .i_raddr(lk_ra),
        .o_rdata(pv_rd)
    );

    alle_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used_ram (
        .i_clk  (i_clk),
        .i_we   (us_we),
        .i_waddr(us_wa),
        .i_wdata(us_wd),
        .i_raddr(lk_ra),
        .o_rdata(us_rd)
    );

    alle_ram #(.WIDTH(DATA_BITS), .DEPTH(SLOTS)) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (dt_we),
        .i_waddr(dt_wa),
        .i_wdata(dt_wd),
        .i_raddr(dt_ra),
        .o_rdata(dt_rd)
    );

    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_count  = r_count;
        n_fresh  = r_fresh;
        n_nxt    = r_nxt;
        n_prv    = r_prv;
        n_cur    = r_cur;
        n_left   = r_left;
        n_pos    = r_pos;
        n_value  = r_value;
        n_done   = 1'b0;
        n_slot   = r_slot;
        n_rdval  = r_rdval;
        n_status = r_status;

        lk_ra = AW'(i_position);
        dt_ra = r_head;
        nx_we = 1'b0;
        nx_wa = pidx;
        nx_wd = r_fresh;
        pv_we = 1'b0;
        pv_wa = pidx;
        pv_wd = r_fresh;
        us_we = 1'b0;
        us_wa = pidx;
        us_wd = 1'b0;
        dt_we = 1'b0;
        dt_wa = r_fresh;
        dt_wd = DATA_BITS'(r_value);

        case (r_state)
            S_INIT: begin
                nx_we = 1'b1;
                nx_wa = r_init;
                nx_wd = (r_init == '0 || r_init == AW'(SLOTS - 1)) ? '0 : r_init + 1'b1;
                pv_we = 1'b1;
                pv_wa = r_init;
                pv_wd = '0;
                us_we = 1'b1;
                us_wa = r_init;
                us_wd = (r_init == '0);
                n_init = r_init + 1'b1;
                if (r_init == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_pos   = i_position;
                    n_value = i_value;
                    case (t_op'(i_operation))
                        OP_INSERT: begin
                            n_state = S_INS_A;
                        end
                        OP_REMOVE: begin
                            n_state = S_REM_A;
                        end
                        OP_READ: begin
                            if (32'(i_position) >= 32'(r_count)) begin
                                n_done   = 1'b1;
                                n_slot   = '0;
                                n_rdval  = '0;
                                n_status = ST_RANGE;
                            end else if (i_position == '0) begin
                                dt_ra   = r_head;
                                n_cur   = r_head;
                                n_state = S_RD_DATA;
                            end else begin
                                lk_ra   = r_head;
                                n_left  = i_position - 8'd1;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_slot   = '0;
                            n_rdval  = '0;
                            n_status = ST_BAD_SLOT;
                        end
                    endcase
                end
            end
            S_INS_A: begin
                if (!pos_ok || !us_rd) begin
                    n_done   = 1'b1;
                    n_slot   = '0;
                    n_rdval  = '0;
                    n_status = ST_BAD_SLOT;
                    n_state  = S_IDLE;
                end else if (r_free == '0) begin
                    n_done   = 1'b1;
                    n_slot   = '0;
                    n_rdval  = '0;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_nxt   = nx_rd;
                    n_fresh = r_free;
                    lk_ra   = r_free;
                    n_state = S_INS_F;
                end
            end
            S_INS_F: begin
                // next link of the fresh slot is the new free head
                n_free = nx_rd;
                dt_we  = 1'b1;
                us_we  = 1'b1;
                us_wa  = r_fresh;
                us_wd  = 1'b1;
                nx_we  = 1'b1;
                nx_wa  = r_fresh;
                if (r_pos == '0) begin
                    nx_wd = (r_count == '0) ? '0 : r_head;
                end else begin
                    nx_wd = r_nxt;
                end
                pv_we   = 1'b1;
                pv_wa   = r_fresh;
                pv_wd   = pidx;
                n_state = S_INS_W;
            end
            S_INS_W: begin
                if (r_pos == '0) begin
                    if (r_count != '0) begin
                        pv_we = 1'b1;
                        pv_wa = r_head;
                    end else begin
                        n_tail = r_fresh;
                    end
                    n_head = r_fresh;
                end else begin
                    if (r_nxt != '0) begin
                        pv_we = 1'b1;
                        pv_wa = r_nxt;
                    end
                    nx_we = 1'b1;
                    nx_wa = pidx;
                    if (r_tail == pidx) begin
                        n_tail = r_fresh;
                    end
                end
                n_count  = r_count + 1'b1;
                n_done   = 1'b1;
                n_slot   = 8'(r_fresh);
                n_rdval  = '0;
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            S_REM_A: begin
                if (r_pos == '0 || !pos_ok || !us_rd) begin
                    n_done   = 1'b1;
                    n_slot   = '0;
                    n_rdval  = '0;
                    n_status = ST_BAD_SLOT;
                    n_state  = S_IDLE;
                end else begin
                    n_nxt   = nx_rd;
                    n_prv   = pv_rd;
                    pv_we   = 1'b1;
                    pv_wd   = '0;
                    nx_we   = 1'b1;
                    nx_wd   = r_free;
                    us_we   = 1'b1;
                    us_wd   = 1'b0;
                    n_state = S_REM_W;
                end
            end
            S_REM_W: begin
                if (r_nxt != '0) begin
                    pv_we = 1'b1;
                    pv_wa = r_nxt;
                    pv_wd = r_prv;
                end
                if (r_prv != '0) begin
                    nx_we = 1'b1;
                    nx_wa = r_prv;
                    nx_wd = r_nxt;
                end
                if (r_head == pidx) begin
                    n_head = r_nxt;
                end
                if (r_tail == pidx) begin
                    n_tail = r_prv;
                end
                n_free = pidx;
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                n_done   = 1'b1;
                n_slot   = '0;
                n_rdval  = '0;
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            S_WALK: begin
                // one link per cycle: read data feeds the next read address
                if (r_left == '0) begin
                    dt_ra   = nx_rd;
                    n_cur   = nx_rd;
                    n_state = S_RD_DATA;
                end else begin
                    lk_ra  = nx_rd;
                    n_left = r_left - 8'd1;
                end
            end
            S_RD_DATA: begin
                n_done = 1'b1;
                if (r_cur == '0) begin
                    n_slot   = '0;
                    n_rdval  = '0;
                    n_status = ST_RANGE;
                end else begin
                    n_slot   = 8'(r_cur);
                    n_rdval  = 32'($signed(dt_rd));
                    n_status = ST_OK;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_cnt = 8'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_free  <= AW'(1);
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fresh  <= n_fresh;
        r_nxt    <= n_nxt;
        r_prv    <= n_prv;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_slot   <= n_slot;
        r_rdval  <= n_rdval;
        r_status <= n_status;
        if (n_done) begin
            r_cnt <= n_cnt;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_slot       = r_slot;
    assign o_read_value = r_rdval;
    assign o_status     = r_status;
    assign o_count      = r_cnt;

endmodule

// ===== tb/sv/tb_top.sv =====
import alle_pkg::*;

localparam int LIST_SLOTS = alle_pkg::SLOTS_DEF;
localparam logic [1:0] OP_ILLEGAL = 2'd3;

class list_scoreboard;
    typedef struct {
        logic [7:0]  slot;
        logic [31:0] read_value;
        t_status     status;
        logic [7:0]  count;
    } list_result;

    logic [31:0] slot_data [LIST_SLOTS];
    logic [7:0]  next_link [LIST_SLOTS];
    logic [7:0]  prev_link [LIST_SLOTS];
    bit          slot_used [LIST_SLOTS];
    logic [7:0]  head_slot;
    logic [7:0]  tail_slot;
    logic [7:0]  free_head;
    int unsigned element_count;
    list_result  pending_results [$];
    int unsigned failures;

    function new();
        for (int i = 0; i < LIST_SLOTS; i++) begin
            slot_data[i] = '0;
            prev_link[i] = '0;
            slot_used[i] = 1'b0;
            next_link[i] = (i == 0 || i == LIST_SLOTS - 1) ? 8'd0 : 8'(i + 1);
        end
        slot_used[0]  = 1'b1;
        head_slot     = '0;
        tail_slot     = '0;
        free_head     = 8'd1;
        element_count = 0;
        failures      = 0;
    endfunction

    function list_result blank_result();
        list_result r;
        r.slot       = '0;
        r.read_value = '0;
        r.status     = ST_OK;
        r.count      = '0;
        return r;
    endfunction

    function list_result insert_after(logic [7:0] after, logic [31:0] val);
        list_result r;
        logic [7:0] fresh;
        logic [7:0] nxt;
        r = blank_result();
        if (!slot_used[after]) begin
            r.status = ST_BAD_SLOT;
            return r;
        end
        if (free_head == 8'd0) begin
            r.status = ST_FULL;
            return r;
        end
        fresh     = free_head;
        free_head = next_link[fresh];
        if (after == 8'd0) begin
            if (element_count == 0) begin
                next_link[fresh] = 8'd0;
                tail_slot        = fresh;
            end else begin
                next_link[fresh]     = head_slot;
                prev_link[head_slot] = fresh;
            end
            prev_link[fresh] = 8'd0;
            head_slot        = fresh;
        end else begin
            nxt = next_link[after];
            if (nxt != 8'd0)
                prev_link[nxt] = fresh;
            next_link[fresh] = nxt;
            prev_link[fresh] = after;
            next_link[after] = fresh;
            if (tail_slot == after)
                tail_slot = fresh;
        end
        slot_used[fresh] = 1'b1;
        slot_data[fresh] = val;
        element_count++;
        r.slot = fresh;
        return r;
    endfunction

    function list_result unlink_slot(logic [7:0] s);
        list_result r;
        logic [7:0] nxt;
        logic [7:0] prv;
        r = blank_result();
        if (s == 8'd0 || !slot_used[s]) begin
            r.status = ST_BAD_SLOT;
            return r;
        end
        nxt = next_link[s];
        prv = prev_link[s];
        if (nxt != 8'd0)
            prev_link[nxt] = prv;
        if (prv != 8'd0)
            next_link[prv] = nxt;
        if (head_slot == s)
            head_slot = nxt;
        if (tail_slot == s)
            tail_slot = prv;
        slot_used[s] = 1'b0;
        prev_link[s] = 8'd0;
        next_link[s] = free_head;
        free_head    = s;
        if (element_count > 0)
            element_count--;
        return r;
    endfunction

    function list_result read_at(logic [7:0] index);
        list_result r;
        logic [7:0] cur;
        r = blank_result();
        if (index >= element_count) begin
            r.status = ST_RANGE;
            return r;
        end
        cur = head_slot;
        for (int i = 0; i < index; i++)
            cur = next_link[cur];
        if (cur == 8'd0) begin
            r.status = ST_RANGE;
            return r;
        end
        r.slot       = cur;
        r.read_value = slot_data[cur];
        return r;
    endfunction

    // random member of the list, 0 when the list is empty
    function logic [7:0] pick_member();
        logic [7:0] cur;
        int unsigned k;
        if (element_count == 0)
            return 8'd0;
        k   = $urandom_range(element_count - 1);
        cur = head_slot;
        repeat (k) cur = next_link[cur];
        return cur;
    endfunction

    function void note_command(logic [1:0] op, logic [7:0] pos, logic [31:0] val);
        list_result r;
        case (op)
            OP_INSERT: r = insert_after(pos, val);
            OP_REMOVE: r = unlink_slot(pos);
            OP_READ:   r = read_at(pos);
            default: begin
                r        = blank_result();
                r.status = ST_BAD_SLOT;
            end
        endcase
        r.count = 8'(element_count);
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] slot, logic [31:0] rd, logic [1:0] status,
                               logic [7:0] count);
        list_result exp;
        if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("result with no command outstanding: slot=%0d value=%h status=%0d count=%0d",
                         slot, rd, status, count);
            return;
        end
        exp = pending_results.pop_front();
        if (exp.slot !== slot || exp.read_value !== rd || exp.status !== status
            || exp.count !== count) begin
            failures++;
            if (failures <= 10)
                $display("mismatch: expected slot=%0d value=%h status=%0d count=%0d, got slot=%0d value=%h status=%0d count=%0d",
                         exp.slot, exp.read_value, exp.status, exp.count,
                         slot, rd, status, count);
        end
    endfunction
endclass

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [7:0]  i_position;
    logic [31:0] i_value;
    logic        o_done;
    logic [7:0]  o_slot;
    logic [31:0] o_read_value;
    logic [1:0]  o_status;
    logic [7:0]  o_count;

    list_scoreboard board;
    int sender_idle_pct;

    array_linked_list_engine_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_done       (o_done),
        .o_slot       (o_slot),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_result(o_slot, o_read_value, o_status, o_count);
    end

    // one command transfer; called and returning at a rising edge
    task automatic send_command(input logic [1:0] op, input logic [7:0] pos,
                                input logic [31:0] val);
        int gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            start       <= 1'b0;
            i_operation <= 2'($urandom);
            i_position  <= 8'($urandom);
            i_value     <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        board.note_command(op, pos, val);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending_results.size() != 0);
    endtask

    task automatic random_command(input int insert_pct);
        logic [1:0]  op;
        logic [7:0]  pos;
        logic [31:0] val;
        int pick;
        pick = $urandom_range(99);
        val  = $urandom;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: val = 32'h0000_0000;
                1: val = 32'hFFFF_FFFF;
                2: val = 32'h7FFF_FFFF;
                default: val = 32'h8000_0000;
            endcase
        end
        if (pick < 8) begin
            // noise: any opcode, any slot or position
            op  = 2'($urandom);
            pos = 8'($urandom);
        end else if (pick < 8 + insert_pct * 92 / 100) begin
            op  = OP_INSERT;
            pos = ($urandom_range(4) == 0) ? 8'd0 : board.pick_member();
        end else if ($urandom_range(1) == 0) begin
            op  = OP_REMOVE;
            pos = board.pick_member();
        end else begin
            op  = OP_READ;
            pos = 8'($urandom_range(board.element_count));
        end
        send_command(op, pos, val);
    endtask

    initial begin
        board           = new();
        sender_idle_pct = 0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_operation    <= OP_INSERT;
        i_position     <= '0;
        i_value        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // errors on the empty list
        send_command(OP_READ, 8'd0, '0);
        send_command(OP_REMOVE, 8'd0, '0);
        send_command(OP_REMOVE, 8'd5, '0);
        send_command(OP_INSERT, 8'd7, 32'h1234_5678);
        send_command(OP_ILLEGAL, 8'd0, '0);
        // front, front, after tail, middle
        send_command(OP_INSERT, 8'd0, 32'h7FFF_FFFF);
        send_command(OP_INSERT, 8'd0, 32'h8000_0000);
        send_command(OP_INSERT, 8'd1, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 8'd2, 32'h0000_0000);
        for (int p = 0; p < 5; p++)
            send_command(OP_READ, 8'(p), '0);
        send_command(OP_READ, 8'd255, '0);
        send_command(OP_INSERT, 8'd255, 32'hA5A5_A5A5);
        // middle, head, tail, then a slot already freed
        send_command(OP_REMOVE, 8'd4, '0);
        send_command(OP_REMOVE, 8'd2, '0);
        send_command(OP_REMOVE, 8'd3, '0);
        send_command(OP_REMOVE, 8'd4, '0);
        send_command(OP_READ, 8'd0, '0);
        send_command(OP_INSERT, 8'd0, 32'h5A5A_5A5A);
        send_command(OP_READ, 8'd1, '0);
        wait_drained();

        repeat (100) random_command(55);
        wait_drained();

        // fill the store completely, then work at the full boundary
        sender_idle_pct = 71;
        while (board.element_count < LIST_SLOTS - 1)
            random_command(100);
        send_command(OP_INSERT, 8'd0, 32'h0BAD_F00D);
        send_command(OP_REMOVE, 8'd255, '0);
        send_command(OP_INSERT, 8'd0, 32'hCAFE_0001);
        send_command(OP_READ, 8'd0, '0);
        send_command(OP_INSERT, 8'd255, 32'h0000_0001);
        send_command(OP_READ, 8'd254, '0);
        repeat (15) random_command(70);
        wait_drained();

        sender_idle_pct = 0;
        repeat (150) random_command(30);
        wait_drained();

        sender_idle_pct = 9;
        repeat (150) random_command(50);
        wait_drained();

        repeat (300) @(posedge i_clk);
        if (board.failures == 0 && board.pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
